// ===== rtl/core/fdssd_pkg.sv =====
package fdssd_pkg;

    // Display geometry.
    localparam int DIGIT_COUNT = 4;
    localparam int DIG_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int FRAME_COUNT = DIGIT_COUNT + 2;
    localparam int FRAME_W     = $clog2(FRAME_COUNT);

    // Command bytes sent to the display controller.
    localparam logic [7:0] DATA_CMD  = 8'h44;
    localparam logic [7:0] ADDR_BASE = 8'hC0;
    localparam logic [7:0] CTRL_BASE = 8'h80;

    // Division by ten through a reciprocal: q = (v * RECIP_10) >> 35.
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = 29;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_EN = 2'd1;

    localparam logic [2:0] RESET_BRIGHTNESS = 3'd3;
    localparam logic       RESET_DISPLAY_EN = 1'b1;

    typedef struct packed {
        logic [2:0] brightness;
        logic       display_enable;
    } t_cfg;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic busy_res;
        logic sequence_done;
        logic load_accepted;
    } t_result;

    // Segment patterns, ones digit in entry 0.
    typedef logic [DIGIT_COUNT-1:0][7:0] t_seg_bytes;

    // Seven-segment pattern of one decimal digit.
    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pattern;
        case (digit)
            4'd0:    pattern = 8'h3f;
            4'd1:    pattern = 8'h06;
            4'd2:    pattern = 8'h5b;
            4'd3:    pattern = 8'h4f;
            4'd4:    pattern = 8'h66;
            4'd5:    pattern = 8'h6d;
            4'd6:    pattern = 8'h7d;
            4'd7:    pattern = 8'h07;
            4'd8:    pattern = 8'h7f;
            4'd9:    pattern = 8'h6f;
            default: pattern = 8'h00;
        endcase
        return pattern;
    endfunction

endpackage

// ===== rtl/core/fdssd_digits.sv =====
module fdssd_digits (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_value,
    output logic                  o_busy,
    output fdssd_pkg::t_seg_bytes o_seg_bytes
);
    import fdssd_pkg::*;

    logic              r_run;
    logic              r_div_phase;
    logic [DIG_W-1:0]  r_digit;
    logic [31:0]       r_val;
    logic [QUOT_W-1:0] r_quot;
    t_seg_bytes        r_seg_bytes;

    logic [63:0] w_product;
    logic [6:0]  w_q10_low;
    logic [3:0]  w_rem;

    // Quotient by ten through the reciprocal multiply.
    assign w_product = r_val * RECIP_10;

    // Remainder: only the low four bits of v - 10q matter, since it is below ten.
    assign w_q10_low = {r_quot[3:0], 3'b000} + {2'b00, r_quot[3:0], 1'b0};
    assign w_rem     = r_val[3:0] - w_q10_low[3:0];

    // Per digit: the multiply step, then the remainder and table lookup step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_div_phase <= 1'b0;
        end else if (i_start) begin
            r_run       <= 1'b1;
            r_div_phase <= 1'b0;
            r_digit     <= '0;
            r_val       <= i_value;
        end else if (r_run) begin
            if (!r_div_phase) begin
                r_quot      <= w_product[RECIP_SHIFT +: QUOT_W];
                r_div_phase <= 1'b1;
            end else begin
                // A digit above the leading one stays blank.
                r_seg_bytes[r_digit] <= (r_val != 32'd0) ? seg_pattern(w_rem) : 8'h00;
                r_val       <= {{(32-QUOT_W){1'b0}}, r_quot};
                r_div_phase <= 1'b0;
                if (r_digit == DIG_W'(DIGIT_COUNT - 1)) begin
                    r_run <= 1'b0;
                end else begin
                    r_digit <= r_digit + 1'b1;
                end
            end
        end
    end

    assign o_busy      = r_run;
    assign o_seg_bytes = r_seg_bytes;

endmodule

// ===== rtl/core/fdssd_seq.sv =====
module fdssd_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_req_type,
    input  fdssd_pkg::t_cfg       i_cfg,
    input  fdssd_pkg::t_seg_bytes i_seg_bytes,
    output logic                  o_load,
    output logic                  o_seg_read,
    output fdssd_pkg::t_result    o_result
);
    import fdssd_pkg::*;

    typedef enum logic [1:0] {
        PART_START,
        PART_BITS,
        PART_ACK,
        PART_STOP
    } t_part;

    logic               r_active, n_active;
    logic               r_clk,    n_clk;
    logic               r_dio,    n_dio;
    t_part              r_part,   n_part;
    logic [1:0]         r_step,   n_step;
    logic [2:0]         r_bit,    n_bit;
    logic               r_byte,   n_byte;
    logic [FRAME_W-1:0] r_frame,  n_frame;

    logic               w_tick;
    logic               w_load;
    logic               w_done;
    logic               w_digit_frame;
    logic               w_last_frame;
    logic [FRAME_W-1:0] w_frame_m1;
    logic [DIG_W-1:0]   w_seg_idx;
    logic [7:0]         w_tx_byte;

    assign w_tick = i_accept && i_req_type && r_active;
    assign w_load = i_accept && !i_req_type && !r_active;

    // Frame kinds: data command first, then one frame per digit, control last.
    assign w_digit_frame = (r_frame != '0) && (r_frame <= FRAME_W'(DIGIT_COUNT));
    assign w_last_frame  = (r_frame == FRAME_W'(DIGIT_COUNT + 1));
    assign w_frame_m1    = r_frame - 1'b1;
    assign w_seg_idx     = w_frame_m1[DIG_W-1:0];

    // Byte on the wire; the control byte follows the registers live.
    always_comb begin
        if (r_frame == '0) begin
            w_tx_byte = DATA_CMD;
        end else if (w_digit_frame) begin
            if (!r_byte) begin
                w_tx_byte = ADDR_BASE + 8'(DIGIT_COUNT) - 8'(r_frame);
            end else begin
                w_tx_byte = i_seg_bytes[w_seg_idx];
            end
        end else begin
            w_tx_byte = CTRL_BASE | {4'b0000, i_cfg.display_enable, i_cfg.brightness};
        end
    end

    // One pin write per tick, or the start of a sequence on a load.
    always_comb begin
        n_active = r_active;
        n_clk    = r_clk;
        n_dio    = r_dio;
        n_part   = r_part;
        n_step   = r_step;
        n_bit    = r_bit;
        n_byte   = r_byte;
        n_frame  = r_frame;
        w_done   = 1'b0;
        if (w_load) begin
            n_active = 1'b1;
            n_part   = PART_START;
            n_step   = 2'd0;
            n_bit    = 3'd0;
            n_byte   = 1'b0;
            n_frame  = '0;
        end else if (w_tick) begin
            n_step = r_step + 2'd1;
            unique case (r_part)
                PART_START: begin
                    // Data high, clock high, data low.
                    if (r_step == 2'd0) begin
                        n_dio = 1'b1;
                    end else if (r_step == 2'd1) begin
                        n_clk = 1'b1;
                    end else begin
                        n_dio  = 1'b0;
                        n_part = PART_BITS;
                        n_step = 2'd0;
                        n_bit  = 3'd0;
                        n_byte = 1'b0;
                    end
                end
                PART_BITS: begin
                    // Clock low, data bit, clock high; least significant bit first.
                    if (r_step == 2'd0) begin
                        n_clk = 1'b0;
                    end else if (r_step == 2'd1) begin
                        n_dio = w_tx_byte[r_bit];
                    end else begin
                        n_clk  = 1'b1;
                        n_step = 2'd0;
                        if (r_bit == 3'd7) begin
                            n_part = PART_ACK;
                        end else begin
                            n_bit = r_bit + 3'd1;
                        end
                    end
                end
                PART_ACK: begin
                    // One clock pulse for the acknowledge slot.
                    if (r_step == 2'd0) begin
                        n_clk = 1'b0;
                    end else begin
                        n_clk  = 1'b1;
                        n_step = 2'd0;
                        if (w_digit_frame && !r_byte) begin
                            n_part = PART_BITS;
                            n_bit  = 3'd0;
                            n_byte = 1'b1;
                        end else begin
                            n_part = PART_STOP;
                        end
                    end
                end
                PART_STOP: begin
                    // Clock low, data low, clock high, data high.
                    if (r_step == 2'd0) begin
                        n_clk = 1'b0;
                    end else if (r_step == 2'd1) begin
                        n_dio = 1'b0;
                    end else if (r_step == 2'd2) begin
                        n_clk = 1'b1;
                    end else begin
                        n_dio  = 1'b1;
                        n_part = PART_START;
                        n_step = 2'd0;
                        if (w_last_frame) begin
                            n_active = 1'b0;
                            n_frame  = '0;
                            w_done   = 1'b1;
                        end else begin
                            n_frame = r_frame + 1'b1;
                        end
                    end
                end
                default: begin
                    n_part = PART_START;
                end
            endcase
        end
    end

    // Sequencer state and line levels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_clk    <= 1'b1;
            r_dio    <= 1'b1;
            r_part   <= PART_START;
            r_step   <= 2'd0;
            r_bit    <= 3'd0;
            r_byte   <= 1'b0;
            r_frame  <= '0;
        end else begin
            r_active <= n_active;
            r_clk    <= n_clk;
            r_dio    <= n_dio;
            r_part   <= n_part;
            r_step   <= n_step;
            r_bit    <= n_bit;
            r_byte   <= n_byte;
            r_frame  <= n_frame;
        end
    end

    assign o_load     = w_load;
    assign o_seg_read = r_active && w_digit_frame && r_byte;

    assign o_result.clk_level     = n_clk;
    assign o_result.dio_level     = n_dio;
    assign o_result.busy_res      = n_active;
    assign o_result.sequence_done = w_done;
    assign o_result.load_accepted = w_load;

endmodule

// ===== rtl/core/fdssd_obuf.sv =====
module fdssd_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fdssd_pkg::t_result i_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output fdssd_pkg::t_result o_data
);
    import fdssd_pkg::*;

    t_result    r_mem [2];
    logic [1:0] r_count;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic       w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign w_pop   = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd_ptr];

    // Two result slots, so a new beat is taken while an older one waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            if (i_push) begin
                r_mem[r_wr_ptr] <= i_data;
                r_wr_ptr        <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== rtl/core/four_digit_seven_segment_serial_driver_top.sv =====
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_req_type, i_value
// out       output     o_out_valid / i_out_stall o_clk_level, o_dio_level, o_busy_res,
//                                               o_sequence_done, o_load_accepted
// cfg       input      i_cfg_we                 i_cfg_index, i_cfg_data
//
// A tick makes one pin write, and a beat can be taken each cycle while o_in_stall is
// low. A load starts the digit splitter, which works in the background and is done
// long before the sequence sends a digit.
// The result of each taken beat is registered in a two-slot output buffer, which
// raises o_in_stall only when both slots hold waiting results.
// Synchronous active-low reset leaves both lines high, the driver idle,
// brightness 3 and the display enabled.
module four_digit_seven_segment_serial_driver_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [31:0]                     i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_clk_level,
    output logic                            o_dio_level,
    output logic                            o_busy_res,
    output logic                            o_sequence_done,
    output logic                            o_load_accepted,
    input  logic                            i_cfg_we,
    input  logic [fdssd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fdssd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fdssd_pkg::*;

    t_cfg       r_cfg;
    logic       w_in_accept;
    logic       w_load;
    logic       w_seg_read;
    logic       w_dig_busy;
    t_seg_bytes w_seg_bytes;
    t_result    w_result;
    t_result    w_out;

    assign w_in_accept = i_in_valid && !o_in_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness     <= RESET_BRIGHTNESS;
            r_cfg.display_enable <= RESET_DISPLAY_EN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BRIGHTNESS: r_cfg.brightness     <= i_cfg_data[2:0];
                CFG_DISPLAY_EN: r_cfg.display_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    fdssd_digits u_digits (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_load),
        .i_value     (i_value),
        .o_busy      (w_dig_busy),
        .o_seg_bytes (w_seg_bytes)
    );

    fdssd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_in_accept),
        .i_req_type  (i_req_type),
        .i_cfg       (r_cfg),
        .i_seg_bytes (w_seg_bytes),
        .o_load      (w_load),
        .o_seg_read  (w_seg_read),
        .o_result    (w_result)
    );

    fdssd_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_accept),
        .i_data  (w_result),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    assign o_clk_level     = w_out.clk_level;
    assign o_dio_level     = w_out.dio_level;
    assign o_busy_res      = w_out.busy_res;
    assign o_sequence_done = w_out.sequence_done;
    assign o_load_accepted = w_out.load_accepted;

    // The digit patterns are settled before the sequencer sends any of them.
    a_digits_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seg_read |-> !w_dig_busy)
        else $error("segment byte sent while digits are still being split");

    // The final pin write ends the sequence.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sequence_done) |-> (!o_busy_res && !o_load_accepted))
        else $error("sequence done reported while still busy");

    // A taken load starts a sequence.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_load_accepted) |-> o_busy_res)
        else $error("accepted load did not start a sequence");

    // Between sequences both lines rest high.
    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_busy_res) |-> (o_clk_level && o_dio_level))
        else $error("line left low while idle");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fdssd_pkg::*;

    // Request codes carried by i_req_type.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Register indexes past the end of the register list; writes there are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Pin-write counts of the frame parts.
    localparam int START_LEN    = 3;
    localparam int BYTE_LEN     = 26;
    localparam int STOP_LEN     = 4;
    localparam int SHORT_FRAME  = START_LEN + BYTE_LEN + STOP_LEN;
    localparam int LONG_FRAME   = START_LEN + 2 * BYTE_LEN + STOP_LEN;
    localparam int TOTAL_WRITES = 2 * SHORT_FRAME + LONG_FRAME * DIGIT_COUNT;

    localparam int RANDOM_PHASES    = 8;
    localparam int BEATS_PER_PHASE  = 93;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES    = 20;
    localparam int CYCLE_LIMIT      = 200000;

    localparam logic [7:0] DIGIT_SEGS [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    // One row of the directed part: a beat repeated reps times, optionally with
    // a hand-written expected result.
    typedef struct packed {
        logic        req;
        logic [31:0] val;
        int          reps;
        bit          typed;
        t_result     want;
    } t_stim_row;

    localparam int DIRECTED_COUNT = 11;
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // A tick while idle right after reset leaves both lines high.
        '{REQ_TICK, 32'd0,         1,   1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
        // Zero loads as all blanks and starts the sequence.
        '{REQ_LOAD, 32'd0,         1,   1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1}},
        // A load while busy is dropped.
        '{REQ_LOAD, 32'hFFFF_FFFF, 1,   1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
        // Start condition: DIO high, CLK high, DIO low.
        '{REQ_TICK, 32'd0,         1,   1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{REQ_TICK, 32'd0,         1,   1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{REQ_TICK, 32'd0,         1,   1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
        // First bit of the data command drops the clock.
        '{REQ_TICK, 32'd0,         1,   1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{REQ_TICK, 32'd0,         TOTAL_WRITES - 5, 1'b0, '0},
        // Final write of the stop condition raises DIO and ends the sequence.
        '{REQ_TICK, 32'd0,         1,   1'b1, '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{REQ_TICK, 32'hFFFF_FFFF, 1,   1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
        '{REQ_LOAD, 32'hFFFF_FFFF, 1,   1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1}}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_req_type;
    logic [31:0]           i_value;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_clk_level;
    logic                  o_dio_level;
    logic                  o_busy_res;
    logic                  o_sequence_done;
    logic                  o_load_accepted;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Hand-written expectation that travels with the beat on the input side.
    bit      beat_typed;
    t_result beat_want;

    // Shadow of the display driver.
    int         seq_pos;
    t_seg_bytes digit_segs;
    logic       line_clk;
    logic       line_dio;
    logic       seq_active;
    logic [2:0] cfg_bright;
    logic       cfg_enable;

    t_result pending_results [$];
    int      mismatches;
    int      cycle_count;
    int      seq_left;
    int      tx_pct;
    int      rx_pct;
    int      hold_requests;
    int      holds_served;
    int      hold_left;

    four_digit_seven_segment_serial_driver_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_clk_level     (o_clk_level),
        .o_dio_level     (o_dio_level),
        .o_busy_res      (o_busy_res),
        .o_sequence_done (o_sequence_done),
        .o_load_accepted (o_load_accepted),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Byte number byte_no of frame number frame_no, as the driver shifts it out.
    function automatic logic [7:0] frame_byte_of(input int frame_no, input int byte_no);
        if (frame_no == 0) begin
            return DATA_CMD;
        end
        if (frame_no <= DIGIT_COUNT) begin
            if (byte_no == 0) begin
                return ADDR_BASE + 8'(DIGIT_COUNT - frame_no);
            end
            return digit_segs[frame_no - 1];
        end
        return CTRL_BASE | {4'b0000, cfg_enable, cfg_bright};
    endfunction

    // Apply pin write number idx of the sequence to the line levels.
    function automatic void apply_pin_write(input int idx);
        int         frame_no;
        int         off;
        int         nbytes;
        int         step;
        logic [7:0] byte_val;
        if (idx < SHORT_FRAME) begin
            frame_no = 0;
            off      = idx;
        end else if (idx - SHORT_FRAME < LONG_FRAME * DIGIT_COUNT) begin
            frame_no = 1 + (idx - SHORT_FRAME) / LONG_FRAME;
            off      = (idx - SHORT_FRAME) % LONG_FRAME;
        end else begin
            frame_no = DIGIT_COUNT + 1;
            off      = idx - SHORT_FRAME - LONG_FRAME * DIGIT_COUNT;
        end
        nbytes = (frame_no >= 1 && frame_no <= DIGIT_COUNT) ? 2 : 1;

        // Start condition.
        if (off < START_LEN) begin
            if (off == 0) begin
                line_dio = 1'b1;
            end else if (off == 1) begin
                line_clk = 1'b1;
            end else begin
                line_dio = 1'b0;
            end
            return;
        end
        off -= START_LEN;

        // Data bits, least significant first, then one acknowledge clock.
        if (off < BYTE_LEN * nbytes) begin
            step = off % BYTE_LEN;
            if (step < 24) begin
                case (step % 3)
                    0: begin
                        line_clk = 1'b0;
                    end
                    1: begin
                        byte_val = frame_byte_of(frame_no, off / BYTE_LEN);
                        line_dio = byte_val[step / 3];
                    end
                    default: begin
                        line_clk = 1'b1;
                    end
                endcase
            end else begin
                line_clk = (step != 24);
            end
            return;
        end
        off -= BYTE_LEN * nbytes;

        // Stop condition.
        case (off)
            0:       line_clk = 1'b0;
            1:       line_dio = 1'b0;
            2:       line_clk = 1'b1;
            default: line_dio = 1'b1;
        endcase
    endfunction

    // Line state and flags that one accepted beat produces.
    function automatic t_result next_line_state(input logic req, input logic [31:0] val);
        t_result     res;
        logic [31:0] rest;
        res = '0;
        if (req == REQ_LOAD) begin
            if (!seq_active) begin
                rest = val;
                for (int k = 0; k < DIGIT_COUNT; k++) begin
                    digit_segs[k] = (rest > 0) ? DIGIT_SEGS[rest % 10] : 8'h00;
                    rest          = rest / 10;
                end
                seq_pos           = 0;
                seq_active        = 1'b1;
                res.load_accepted = 1'b1;
            end
        end else if (seq_active) begin
            apply_pin_write(seq_pos);
            seq_pos++;
            if (seq_pos >= TOTAL_WRITES) begin
                seq_active        = 1'b0;
                seq_pos           = 0;
                res.sequence_done = 1'b1;
            end
        end
        res.clk_level = line_clk;
        res.dio_level = line_dio;
        res.busy_res  = seq_active;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic got, input logic want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %b, expected %b", name, got, want));
        end
    endtask

    // Predict each accepted input beat and check each accepted output beat.
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                want = next_line_state(i_req_type, i_value);
                if (beat_typed) begin
                    want = beat_want;
                end
                pending_results.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = pending_results.pop_front();
                    check_field("clk_level", o_clk_level, want.clk_level);
                    check_field("dio_level", o_dio_level, want.dio_level);
                    check_field("busy_res", o_busy_res, want.busy_res);
                    check_field("sequence_done", o_sequence_done, want.sequence_done);
                    check_field("load_accepted", o_load_accepted, want.load_accepted);
                end
            end
        end
    end

    // Receiver stall: random, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one beat, at times after a random gap, and wait until it is taken.
    task automatic send_beat(input logic req, input logic [31:0] val, input bit typed,
                             input t_result want);
        if (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_value    <= val;
        beat_typed <= typed;
        beat_want  <= want;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        if (req == REQ_LOAD) begin
            if (seq_left == 0) begin
                seq_left = TOTAL_WRITES;
            end
        end else if (seq_left > 0) begin
            seq_left--;
        end
    endtask

    // Stop sending and wait until every expected result beat has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_BRIGHTNESS: cfg_bright = data[2:0];
            CFG_DISPLAY_EN: cfg_enable = data[0];
            default: ;
        endcase
    endtask

    // Extremes first, then random settings; unused indexes and upper bits get junk.
    task automatic program_config(input int ph);
        logic [2:0] bright_data;
        logic [2:0] enable_data;
        bright_data = (ph == 0) ? 3'd0 : (ph == 1) ? 3'd7 : 3'($urandom);
        enable_data = (ph == 0) ? 3'b110 : (ph == 1) ? 3'b001 : 3'($urandom);
        wait_drained();
        write_reg(CFG_BRIGHTNESS, bright_data);
        write_reg(CFG_DISPLAY_EN, enable_data);
        write_reg(CFG_SPARE_2, 3'($urandom));
        write_reg(CFG_SPARE_3, 3'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Random values, extremes, and values near the decimal boundaries where leading digits go blank.
    function automatic logic [31:0] pick_value();
        logic [31:0] pow;
        int          digits;
        pow    = 32'd1;
        digits = $urandom_range(0, 9);
        repeat (digits) pow = pow * 10;
        case ($urandom_range(5))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
            2:       return pow - 1;
            3:       return pow;
            4:       return $urandom_range(0, 9999);
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // Mostly full sequences; the rest are ticks while idle and loads while busy.
    task automatic send_random_beat();
        logic [31:0] noise;
        noise = $urandom;
        if (seq_left == 0) begin
            if ($urandom_range(99) < 85) begin
                send_beat(REQ_LOAD, pick_value(), 1'b0, '0);
            end else begin
                send_beat(REQ_TICK, noise, 1'b0, '0);
            end
        end else if ($urandom_range(99) < 4) begin
            send_beat(REQ_LOAD, noise, 1'b0, '0);
        end else begin
            send_beat(REQ_TICK, noise, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_req_type    = REQ_LOAD;
        i_value       = '0;
        i_out_stall   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_BRIGHTNESS;
        i_cfg_data    = '0;
        beat_typed    = 1'b0;
        beat_want     = '0;
        seq_pos       = 0;
        digit_segs    = '0;
        line_clk      = 1'b1;
        line_dio      = 1'b1;
        seq_active    = 1'b0;
        cfg_bright    = RESET_BRIGHTNESS;
        cfg_enable    = RESET_DISPLAY_EN;
        mismatches    = 0;
        cycle_count   = 0;
        seq_left      = 0;
        tx_pct        = 0;
        rx_pct        = 0;
        hold_requests = 0;
        holds_served  = 0;
        hold_left     = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows under the reset configuration.
        for (int r = 0; r < DIRECTED_COUNT; r++) begin
            repeat (DIRECTED_ROWS[r].reps) begin
                send_beat(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].val,
                          DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
            end
        end

        // Random phases; the configuration changes at each phase start, which
        // usually falls in the middle of a sequence.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            tx_pct = (ph % 4 == 1) ? 53 : (ph % 4 == 3) ? 20 : 0;
            rx_pct = (ph % 4 == 2) ? 53 : (ph % 4 == 3) ? 20 : 0;
            program_config(ph);
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                // The receiver holds off while beats keep coming, so the block fills up.
                if (ph == 4 && n == 20) begin
                    hold_requests++;
                end
                if (ph == 6 && n == 60) begin
                    wait_drained();
                end
                send_random_beat();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fdssd_pkg.sv
rtl/core/fdssd_digits.sv
rtl/core/fdssd_seq.sv
rtl/core/fdssd_obuf.sv
rtl/core/four_digit_seven_segment_serial_driver_top.sv
tb/tb_top.sv
